// ===== hdl/bed_pkg.sv =====
// bed_pkg: shared constants and types of the banded edit distance block
// no dependencies; used by bed_if, bed_cell and banded_edit_distance
`default_nettype none

package bed_pkg;

  localparam int MAX_LEN_DEF = 32;

  // wide enough for column values and band sums at any length up to 255
  localparam int VAL_W = 10;

  localparam int SYM_W  = 8;
  localparam int DIST_W = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [SYM_W-1:0]  SYM_N    = 8'h4E;
  localparam logic [DIST_W-1:0] DIST_MAX = 6'd63;

  localparam logic [CFG_IDX_W-1:0] REG_SKIP_N = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ED = 1'd1;

  localparam logic [CFG_DATA_W-1:0] MAX_ED_RESET = 6'd2;

  typedef struct packed {
    logic [VAL_W-1:0] up;
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] diag;
    logic [SYM_W-1:0] c1;
    logic [SYM_W-1:0] c2;
    logic             skip_n;
    logic [VAL_W-1:0] off;
    logic [VAL_W-1:0] best;
  } cell_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] best;
  } cell_out_t;

endpackage

`default_nettype wire

// ===== hdl/bed_if.sv =====
// bed_if: valid/ready channels for symbol beats and result beats
// depends on bed_pkg for field widths
`default_nettype none

interface bed_item_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [bed_pkg::SYM_W-1:0]    symbol;
  logic                         has_symbol;
  logic                         last;

  modport source (output valid, output req_type, output symbol, output has_symbol,
                  output last, input ready);
  modport sink (input valid, input req_type, input symbol, input has_symbol,
                input last, output ready);
endinterface

interface bed_result_if;
  logic                         valid;
  logic                         ready;
  logic [bed_pkg::DIST_W-1:0]   distance;
  logic                         exceeded;
  logic                         too_long;

  modport source (output valid, output distance, output exceeded, output too_long,
                  input ready);
  modport sink (input valid, input distance, input exceeded, input too_long,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/bed_cell.sv =====
// bed_cell: shared cell unit, one banded levenshtein cell and running band minimum
// depends on bed_pkg for cell_in_t and cell_out_t
`default_nettype none

module bed_cell (
  input  bed_pkg::cell_in_t  cin,
  output bed_pkg::cell_out_t cout
);

  logic                      match;
  logic [bed_pkg::VAL_W-1:0] v_up;
  logic [bed_pkg::VAL_W-1:0] v_left;
  logic [bed_pkg::VAL_W-1:0] v_diag;
  logic [bed_pkg::VAL_W-1:0] v_min1;
  logic [bed_pkg::VAL_W-1:0] v;
  logic [bed_pkg::VAL_W-1:0] v_off;

  always_comb begin
    match = (cin.c1 == cin.c2) ||
            (cin.skip_n && ((cin.c1 == bed_pkg::SYM_N) || (cin.c2 == bed_pkg::SYM_N)));
    v_up   = cin.up + bed_pkg::VAL_W'(1);
    v_left = cin.left + bed_pkg::VAL_W'(1);
    v_diag = match ? cin.diag : cin.diag + bed_pkg::VAL_W'(1);
    v_min1 = (v_left < v_up) ? v_left : v_up;
    v      = (v_diag < v_min1) ? v_diag : v_min1;
    v_off  = v + cin.off;
    cout.v    = v;
    cout.best = (v_off < cin.best) ? v_off : cin.best;
  end

endmodule

`default_nettype wire

// ===== hdl/banded_edit_distance.sv =====
// banded_edit_distance: top level, symbol stores, column memory and row sequencer
// depends on bed_pkg, bed_if and bed_cell
//
// usage: the item channel carries symbol beats; req_type 0 beats build the first
// string, req_type 1 beats walk the second string, last closes each string.
// the result channel gives one beat (distance, exceeded, too_long) per second
// string, after its last beat. skip_n and max_ed are written through cfg_we,
// cfg_index and cfg_data while the block is idle.
// steps: a first-string beat is taken while idle; its last beat adds a column
// load of first_length + 1 entries. a live second-string symbol passes ST_LO,
// ST_LOAD, then ST_CELL per band cell past the left edge (at most 2 * max_ed,
// bounded by first_length), the single shared cell unit handling one cell per
// cycle from the column memory. a last beat leads via ST_FIN to the result load.
// the item channel is not ready while a beat is in work. a stalled result waits
// in the output register; the block keeps taking beats and only holds its next
// result until the register is free.
// reset: skip_n 0, max_ed 2, awaiting a first string, no result pending; the
// stores need no clearing pass.
`default_nettype none

module banded_edit_distance #(
  parameter int MAX_LEN = bed_pkg::MAX_LEN_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  bed_item_if.sink                                item,
  bed_result_if.source                            result,
  input  wire logic                               cfg_we,
  input  wire logic [bed_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bed_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int SW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int VW    = bed_pkg::VAL_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_LO   = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_CELL = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]                        state;
  logic                              skip_n;
  logic [bed_pkg::CFG_DATA_W-1:0]    max_ed;
  logic [LEN_W-1:0]                  first_length;
  logic [LEN_W-1:0]                  row_number;
  logic                              stopped;
  logic [VW-1:0]                     held_distance;
  logic                              second_phase;
  logic                              length_overflow;
  logic                              pend_last;
  logic [LEN_W-1:0]                  ptr;
  logic [LEN_W-1:0]                  lo;
  logic [LEN_W-1:0]                  hi;
  logic [bed_pkg::SYM_W-1:0]         sym;
  logic [VW-1:0]                     diag;
  logic [VW-1:0]                     left;
  logic [VW-1:0]                     best;
  logic                              out_valid;
  logic [bed_pkg::DIST_W-1:0]        out_distance;
  logic                              out_exceeded;
  logic                              out_too_long;

  logic [bed_pkg::SYM_W-1:0]         str_mem [MAX_LEN];
  logic [VW-1:0]                     col_mem [MAX_LEN+1];
  logic [bed_pkg::SYM_W-1:0]         str_rdata;
  logic [VW-1:0]                     col_rdata;
  logic [SW-1:0]                     str_raddr;
  logic [LEN_W-1:0]                  col_raddr;
  logic                              col_we;
  logic [LEN_W-1:0]                  col_waddr;
  logic [VW-1:0]                     col_wdata;

  logic                              accept;
  logic [LEN_W-1:0]                  len_base;
  logic [LEN_W-1:0]                  r_next;
  logic [VW-1:0]                     r_w;
  logic [VW-1:0]                     med_w;
  logic [VW-1:0]                     len_w;
  logic [VW-1:0]                     lo_raw;
  logic [VW-1:0]                     hi_raw;
  logic [LEN_W-1:0]                  lo_c;
  logic [LEN_W-1:0]                  hi_c;
  logic [LEN_W-1:0]                  off;
  logic [VW-1:0]                     final_d;
  logic                              out_free;

  bed_pkg::cell_in_t                 cin;
  bed_pkg::cell_out_t                cout;

  bed_cell u_cell (
    .cin  (cin),
    .cout (cout)
  );

  assign item.ready       = (state == ST_IDLE);
  assign accept           = item.valid && item.ready;
  assign result.valid     = out_valid;
  assign result.distance  = out_distance;
  assign result.exceeded  = out_exceeded;
  assign result.too_long  = out_too_long;
  assign out_free         = !out_valid || result.ready;

  // band edges for the next row, cell offset from the diagonal and final distance
  always_comb begin
    len_base = second_phase ? '0 : first_length;
    r_next   = row_number + LEN_W'(1);
    r_w      = VW'(r_next);
    med_w    = VW'(max_ed);
    len_w    = VW'(first_length);
    lo_raw   = (r_w > med_w) ? r_w - med_w : '0;
    hi_raw   = r_w + med_w;
    lo_c     = (lo_raw > len_w) ? first_length : lo_raw[LEN_W-1:0];
    hi_c     = (hi_raw > len_w) ? first_length : hi_raw[LEN_W-1:0];
    off      = (ptr > row_number) ? ptr - row_number : row_number - ptr;
    final_d  = stopped ? held_distance : col_rdata;
  end

  always_comb begin
    cin.up     = col_rdata;
    cin.left   = left;
    cin.diag   = diag;
    cin.c1     = str_rdata;
    cin.c2     = sym;
    cin.skip_n = skip_n;
    cin.off    = VW'(off);
    cin.best   = best;
  end

  // memory addressing
  always_comb begin
    col_raddr = first_length;
    str_raddr = '0;
    col_we    = 1'b0;
    col_waddr = ptr;
    col_wdata = VW'(ptr);
    unique case (state)
      ST_INIT: begin
        col_we = 1'b1;
      end
      ST_LO: begin
        col_raddr = lo;
      end
      ST_LOAD: begin
        col_we    = 1'b1;
        col_waddr = lo;
        col_wdata = VW'(row_number);
        col_raddr = (lo == hi) ? lo : lo + LEN_W'(1);
        str_raddr = lo[SW-1:0];
      end
      ST_CELL: begin
        col_we    = 1'b1;
        col_wdata = cout.v;
        col_raddr = (ptr == hi) ? ptr : ptr + LEN_W'(1);
        str_raddr = ptr[SW-1:0];
      end
      ST_IDLE, ST_FIN, ST_DONE: begin
        col_raddr = first_length;
      end
      default: begin
        col_raddr = first_length;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    col_rdata <= col_mem[col_raddr];
    str_rdata <= str_mem[str_raddr];
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    if (accept && !item.req_type && item.has_symbol && (len_base < LEN_W'(MAX_LEN))) begin
      str_mem[len_base[SW-1:0]] <= item.symbol;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_n <= 1'b0;
      max_ed <= bed_pkg::MAX_ED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bed_pkg::REG_SKIP_N: skip_n <= cfg_data[0];
        bed_pkg::REG_MAX_ED: max_ed <= cfg_data;
        default: ;
      endcase
    end
  end

  // row sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      first_length    <= '0;
      row_number      <= '0;
      stopped         <= 1'b0;
      held_distance   <= '0;
      second_phase    <= 1'b0;
      length_overflow <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && !item.req_type) begin
            if (second_phase) begin
              first_length    <= '0;
              length_overflow <= 1'b0;
              row_number      <= '0;
              stopped         <= 1'b0;
              held_distance   <= '0;
              second_phase    <= 1'b0;
            end
            if (item.has_symbol) begin
              if (len_base < LEN_W'(MAX_LEN)) begin
                first_length <= len_base + LEN_W'(1);
              end else begin
                length_overflow <= 1'b1;
              end
            end
            if (item.last) begin
              row_number    <= '0;
              stopped       <= 1'b0;
              held_distance <= '0;
              second_phase  <= 1'b1;
              ptr           <= '0;
              state         <= ST_INIT;
            end
          end else if (accept && second_phase) begin
            pend_last <= item.last;
            sym       <= item.symbol;
            if (item.has_symbol && (row_number >= LEN_W'(MAX_LEN))) begin
              length_overflow <= 1'b1;
              if (item.last) state <= ST_FIN;
            end else if (item.has_symbol) begin
              row_number <= r_next;
              if (!stopped) begin
                lo    <= lo_c;
                hi    <= hi_c;
                state <= ST_LO;
              end else if (item.last) begin
                state <= ST_FIN;
              end
            end else if (item.last) begin
              state <= ST_FIN;
            end
          end
        end
        ST_INIT: begin
          if (ptr == first_length) begin
            state <= ST_IDLE;
          end else begin
            ptr <= ptr + LEN_W'(1);
          end
        end
        ST_LO: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          diag <= col_rdata;
          left <= VW'(row_number);
          best <= VW'(row_number);
          ptr  <= lo + LEN_W'(1);
          if (lo == hi) begin
            if (VW'(row_number) > VW'(max_ed)) begin
              stopped       <= 1'b1;
              held_distance <= VW'(row_number);
            end
            state <= pend_last ? ST_FIN : ST_IDLE;
          end else begin
            state <= ST_CELL;
          end
        end
        ST_CELL: begin
          diag <= col_rdata;
          left <= cout.v;
          best <= cout.best;
          if (ptr == hi) begin
            if (cout.best > VW'(max_ed)) begin
              stopped       <= 1'b1;
              held_distance <= cout.best;
            end
            state <= pend_last ? ST_FIN : ST_IDLE;
          end else begin
            ptr <= ptr + LEN_W'(1);
          end
        end
        ST_FIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            out_distance    <= (final_d > VW'(bed_pkg::DIST_MAX)) ? bed_pkg::DIST_MAX
                                                                  : final_d[bed_pkg::DIST_W-1:0];
            out_exceeded    <= stopped;
            out_too_long    <= length_overflow;
            first_length    <= '0;
            row_number      <= '0;
            stopped         <= 1'b0;
            held_distance   <= '0;
            second_phase    <= 1'b0;
            length_overflow <= 1'b0;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cell_in_band: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CELL) |-> ((ptr > lo) && (ptr <= hi)))
    else $error("cell pointer outside band");

  a_band_edges: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_LOAD) || (state == ST_CELL)) |-> ((lo <= hi) && (hi <= first_length)))
    else $error("band edges beyond first string");

  a_row_live: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_LO) || (state == ST_LOAD) || (state == ST_CELL)) |->
      (second_phase && !stopped))
    else $error("row work outside an open comparison");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> ((state == ST_IDLE) && !out_valid && !second_phase))
    else $error("block not idle after reset");
`endif

endmodule

`default_nettype wire
